@@ rtl/websocket_frame_deframer_assert.svh @@
// Assertion macros shared by the websocket deframer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wsd assertion failed");

// next-cycle implication, disabled in reset
`define WSD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wsd assertion failed");

`endif

@@ rtl/wsd_pkg.sv @@
// Types and constants for the websocket frame deframer.
// No dependencies; used by every RTL module of the block.
package wsd_pkg;

	localparam int LENGTH_BITS_DEF = 64;

	localparam logic [7:0] HDR_TOP_BIT   = 8'h80;
	localparam logic [7:0] OPCODE_MASK   = 8'h0f;
	localparam logic [7:0] LEN7_MASK     = 8'h7f;
	localparam logic [6:0] LEN7_EXT16    = 7'd126;
	localparam logic [6:0] LEN7_EXT64    = 7'd127;
	localparam logic [3:0] EXT16_BYTES   = 4'd2;
	localparam logic [3:0] EXT64_BYTES   = 4'd8;
	localparam logic [3:0] KEY_BYTES     = 4'd4;
	localparam logic [3:0] OPC_CLOSE     = 4'h8;

	typedef enum logic [2:0] {
		PH_HDR0   = 3'd0,
		PH_HDR1   = 3'd1,
		PH_EXTLEN = 3'd2,
		PH_KEY    = 3'd3,
		PH_DATA   = 3'd4
	} wsd_phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [3:0] frame_opcode;
		logic       end_of_frame;
		logic       empty_frame;
		logic       close_request;
	} wsd_result_t;

endpackage

@@ rtl/wsd_parser.sv @@
// Frame header/payload parser: parse state registers and next-state logic.
// Depends on wsd_pkg and websocket_frame_deframer_assert.svh.
`include "websocket_frame_deframer_assert.svh"

module wsd_parser #(
	parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            byte_in,
	output logic                  res_gen,
	output wsd_pkg::wsd_result_t  res
);

	wsd_pkg::wsd_phase_t    phase_q, phase_n;
	logic                   final_q, final_n;
	logic [3:0]             opcode_q, opcode_n;
	logic                   masked_q, masked_n;
	logic [3:0]             cnt_q, cnt_n;
	logic [LENGTH_BITS-1:0] rem_q, rem_n;
	logic [31:0]            key_q, key_n;
	logic [1:0]             kidx_q, kidx_n;
	logic                   closed_q, closed_n;

	logic       end_hdr, begin_pl, do_close;
	logic [6:0] len7;
	logic [1:0] key_sel;
	logic [7:0] key_byte, data_v;

	assign len7     = 7'(byte_in & wsd_pkg::LEN7_MASK);
	assign key_sel  = 2'd3 - kidx_q;
	assign key_byte = key_q[{key_sel, 3'b000} +: 8];
	assign data_v   = byte_in ^ key_byte;

	always_comb begin
		phase_n  = phase_q;
		final_n  = final_q;
		opcode_n = opcode_q;
		masked_n = masked_q;
		cnt_n    = cnt_q;
		rem_n    = rem_q;
		key_n    = key_q;
		kidx_n   = kidx_q;
		closed_n = closed_q;
		end_hdr  = 1'b0;
		begin_pl = 1'b0;
		do_close = 1'b0;
		res_gen  = 1'b0;
		res      = '0;
		res.frame_opcode = opcode_q;

		case (phase_q)
			wsd_pkg::PH_HDR1: begin
				masked_n = (byte_in & wsd_pkg::HDR_TOP_BIT) != 8'd0;
				key_n    = '0;
				if (len7 == wsd_pkg::LEN7_EXT16 || len7 == wsd_pkg::LEN7_EXT64) begin
					rem_n   = '0;
					cnt_n   = (len7 == wsd_pkg::LEN7_EXT16) ?
						wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
					phase_n = wsd_pkg::PH_EXTLEN;
				end else begin
					rem_n   = LENGTH_BITS'(len7);
					end_hdr = 1'b1;
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				rem_n = {rem_q[LENGTH_BITS-9:0], byte_in};
				cnt_n = cnt_q - 4'd1;
				if (cnt_n == 4'd0) begin
					end_hdr = 1'b1;
				end
			end
			wsd_pkg::PH_KEY: begin
				key_n = {key_q[23:0], byte_in};
				cnt_n = cnt_q - 4'd1;
				if (cnt_n == 4'd0) begin
					begin_pl = 1'b1;
				end
			end
			wsd_pkg::PH_DATA: begin
				kidx_n = kidx_q + 2'd1;
				rem_n  = rem_q - LENGTH_BITS'(1);
				if (rem_q == LENGTH_BITS'(1)) begin
					phase_n = wsd_pkg::PH_HDR0;
					if (opcode_q == wsd_pkg::OPC_CLOSE) begin
						do_close = 1'b1;
					end else if (final_q) begin
						res_gen          = 1'b1;
						res.payload_byte = data_v;
						res.end_of_frame = 1'b1;
					end
				end else if (opcode_q != wsd_pkg::OPC_CLOSE && final_q) begin
					res_gen          = 1'b1;
					res.payload_byte = data_v;
				end
			end
			default: begin
				final_n  = (byte_in & wsd_pkg::HDR_TOP_BIT) != 8'd0;
				opcode_n = 4'(byte_in & wsd_pkg::OPCODE_MASK);
				phase_n  = wsd_pkg::PH_HDR1;
			end
		endcase

		if (end_hdr) begin
			if (masked_n) begin
				cnt_n   = wsd_pkg::KEY_BYTES;
				phase_n = wsd_pkg::PH_KEY;
			end else begin
				key_n    = '0;
				begin_pl = 1'b1;
			end
		end

		if (begin_pl) begin
			kidx_n = 2'd0;
			if (rem_n != '0) begin
				phase_n = wsd_pkg::PH_DATA;
			end else begin
				phase_n = wsd_pkg::PH_HDR0;
				if (opcode_q == wsd_pkg::OPC_CLOSE) begin
					do_close = 1'b1;
				end else if (final_q) begin
					res_gen          = 1'b1;
					res.end_of_frame = 1'b1;
					res.empty_frame  = 1'b1;
				end
			end
		end

		if (do_close) begin
			closed_n          = 1'b1;
			phase_n           = wsd_pkg::PH_HDR0;
			res_gen           = 1'b1;
			res.end_of_frame  = 1'b1;
			res.close_request = 1'b1;
		end

		// after close every byte is swallowed
		if (closed_q) begin
			phase_n  = phase_q;
			final_n  = final_q;
			opcode_n = opcode_q;
			masked_n = masked_q;
			cnt_n    = cnt_q;
			rem_n    = rem_q;
			key_n    = key_q;
			kidx_n   = kidx_q;
			closed_n = closed_q;
			res_gen  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsd_pkg::PH_HDR0;
			final_q  <= 1'b0;
			opcode_q <= 4'd0;
			masked_q <= 1'b0;
			cnt_q    <= 4'd0;
			rem_q    <= '0;
			key_q    <= '0;
			kidx_q   <= 2'd0;
			closed_q <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_n;
			final_q  <= final_n;
			opcode_q <= opcode_n;
			masked_q <= masked_n;
			cnt_q    <= cnt_n;
			rem_q    <= rem_n;
			key_q    <= key_n;
			kidx_q   <= kidx_n;
			closed_q <= closed_n;
		end
	end

	`WSD_ASSERT_NXT(a_closed_sticks, clk, arst_n, closed_q, closed_q)
	`WSD_ASSERT_IMP(a_no_result_after_close, clk, arst_n, closed_q, !res_gen)
	`WSD_ASSERT_IMP(a_key_only_masked, clk, arst_n, phase_q == wsd_pkg::PH_KEY, masked_q)
	`WSD_ASSERT_IMP(a_data_nonzero, clk, arst_n, phase_q == wsd_pkg::PH_DATA, rem_q != '0)

endmodule

@@ rtl/wsd_out_reg.sv @@
// Result register: holds one result until the consumer takes it.
// Depends on wsd_pkg and websocket_frame_deframer_assert.svh.
`include "websocket_frame_deframer_assert.svh"

module wsd_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  wsd_pkg::wsd_result_t res_in,
	output logic                 free,
	input  logic                 res_stall,
	output logic                 res_valid,
	output wsd_pkg::wsd_result_t res_q
);

	logic valid_q;

	assign free      = !valid_q || !res_stall;
	assign res_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	`WSD_ASSERT_IMP(a_no_overwrite, clk, arst_n, load, free)

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// Channel   | handshake             | payload
// rx        | rx_valid / rx_stall   | rx_byte
// res       | res_valid / res_stall | payload_byte, frame_opcode, end_of_frame,
//           |                       | empty_frame, close_request
// One byte per clock sustained except for the wait described below; a byte
// is held in the input register, then is parsed and its result (if any)
// lands in the result register.
// A byte that yields a result waits in the input register while the result
// register is full and stalled; bytes that yield none never wait.
// Asynchronous active-low reset returns to the first header byte, not closed.
// Top level of the websocket frame deframer; depends on wsd_pkg, wsd_parser,
// wsd_out_reg.

module websocket_frame_deframer #(
	parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] payload_byte,
	output logic [3:0] frame_opcode,
	output logic       end_of_frame,
	output logic       empty_frame,
	output logic       close_request
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 res_gen, out_free, adv;
	wsd_pkg::wsd_result_t res_c, res_q;

	// advance unless a result is due and the result register can't take it
	assign adv      = valid_s1 && (!res_gen || out_free);
	assign rx_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	wsd_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (adv),
		.byte_in (byte_s1),
		.res_gen (res_gen),
		.res     (res_c)
	);

	wsd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && res_gen),
		.res_in    (res_c),
		.free      (out_free),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_q     (res_q)
	);

	assign payload_byte  = res_q.payload_byte;
	assign frame_opcode  = res_q.frame_opcode;
	assign end_of_frame  = res_q.end_of_frame;
	assign empty_frame   = res_q.empty_frame;
	assign close_request = res_q.close_request;

endmodule
